// File: hdl/cbs_pkg.sv
package cbs_pkg;

  // Fixed field widths of the stream payloads and registers
  localparam int ACT_BITS    = 2;
  localparam int LEN_BITS    = 8;
  localparam int POLICY_BITS = 2;
  localparam int QUANT_BITS  = 8;
  localparam int PROC_BITS   = 3;
  localparam int TIME_BITS   = 11;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 8;

  // Input actions (carried on s_tuser)
  localparam logic [ACT_BITS-1:0] ACT_CLEAR   = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_APPEND  = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_REWIND  = 2'd2;
  localparam logic [ACT_BITS-1:0] ACT_REQUEST = 2'd3;

  // Scheduling policies; the unused code falls back to first come
  localparam logic [POLICY_BITS-1:0] POL_FCFS = 2'd0;
  localparam logic [POLICY_BITS-1:0] POL_SJF  = 2'd1;
  localparam logic [POLICY_BITS-1:0] POL_RR   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_POLICY  = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_QUANTUM = 1'd1;

  localparam logic [QUANT_BITS-1:0] QUANT_RESET = 8'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } state_t;

  // Broadcast command to every cell
  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_CLEAR,
    CELL_APPEND,
    CELL_REWIND,
    CELL_RUN
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rr;
    logic     sjf;
  } cell_ctrl_t;

  // Flags of the search wave that moves down the chain
  typedef struct packed {
    logic       found;
    logic       wrap_found;
    logic [1:0] elig_cnt;
  } wave_flags_t;

endpackage

// File: hdl/cbs_cell.sv
module cbs_cell #(
  parameter int IDX_W      = 3,
  parameter int BURST_BITS = 8,
  parameter int CELL_INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cbs_pkg::cell_ctrl_t      ctrl,
  input  logic [IDX_W-1:0]         addr,
  input  logic [BURST_BITS-1:0]    data,
  input  logic [IDX_W-1:0]         thresh,
  input  cbs_pkg::wave_flags_t     in_flags,
  input  logic [IDX_W-1:0]         in_idx,
  input  logic [BURST_BITS-1:0]    in_rem,
  input  logic [BURST_BITS-1:0]    in_key,
  input  logic [IDX_W-1:0]         in_widx,
  input  logic [BURST_BITS-1:0]    in_wrem,
  output cbs_pkg::wave_flags_t     out_flags,
  output logic [IDX_W-1:0]         out_idx,
  output logic [BURST_BITS-1:0]    out_rem,
  output logic [BURST_BITS-1:0]    out_key,
  output logic [IDX_W-1:0]         out_widx,
  output logic [BURST_BITS-1:0]    out_wrem
);
  import cbs_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic                  used;
  logic                  fin;
  logic [BURST_BITS-1:0] burst;
  logic [BURST_BITS-1:0] rem;

  logic        hit;
  logic        elig;
  logic        hi_ok;
  logic        take;
  logic        wtake;
  wave_flags_t flags_next;

  assign hit = (addr == MY_IDX);

  // Per-process state
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_CLEAR: used <= 1'b0;
        CELL_APPEND: if (hit) begin
          used <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_APPEND: if (hit) begin
        burst <= data;
        rem   <= data;
        fin   <= 1'b0;
      end
      CELL_REWIND: begin
        rem <= burst;
        fin <= 1'b0;
      end
      CELL_RUN: if (hit) begin
        rem <= rem - data;
        if (rem == data) begin
          fin <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Candidate selection for the passing wave
  always_comb begin
    elig  = used && (ctrl.rr ? (rem != '0) : !fin);
    hi_ok = (MY_IDX >= thresh);
    take  = elig && hi_ok && (!in_flags.found || (ctrl.sjf && (burst < in_key)));
    wtake = elig && !in_flags.wrap_found;
    flags_next.found      = in_flags.found || (elig && hi_ok);
    flags_next.wrap_found = in_flags.wrap_found || elig;
    if (in_flags.elig_cnt[1]) begin
      flags_next.elig_cnt = 2'd2;
    end else begin
      flags_next.elig_cnt = in_flags.elig_cnt + {1'b0, elig};
    end
  end

  // Hand the wave to the next cell
  always_ff @(posedge clk) begin
    out_flags <= flags_next;
    out_idx   <= take ? MY_IDX : in_idx;
    out_rem   <= take ? rem : in_rem;
    out_key   <= take ? burst : in_key;
    out_widx  <= wtake ? MY_IDX : in_widx;
    out_wrem  <= wtake ? rem : in_wrem;
  end

endmodule

// File: hdl/cpu_burst_scheduler.sv
// CPU burst scheduler.
// Input stream (s_*): s_tuser carries the action (clear table, append process,
// rewind, request slice); s_tdata carries the burst length of an append.
// Output stream (m_*): one transfer per slice request. m_tuser is high when a
// slice was granted, m_tdata holds process index, start and end time, and
// m_tlast marks the slice that completes the schedule. An exhausted schedule
// returns m_tuser low with all other fields zero.
// Config port: cfg_we writes register cfg_addr (0 policy, 1 quantum).
// Sequencing: clear, append and rewind are done in the idle state. A request
// walks a search wave down the row of MAX_PROCS process cells, one cell per
// cycle, then passes to a commit state: the result is loaded into the output
// register when commit is left, and the next item is taken back in idle.
// Reset empties the table, zeroes time, sets first-come policy, quantum 2.
// A stalled m_tready holds the result in the output register; a following
// request waits in its commit state until that register is free.
module cpu_burst_scheduler #(
  parameter int MAX_PROCS  = 8,
  parameter int BURST_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // burst_length[7:0]
  input  logic [cbs_pkg::ACT_BITS-1:0]        s_tuser,  // action[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // proc_index[2:0], start_time[13:3], end_time[24:14], zero fill above
  output logic [31:0]                         m_tdata,
  output logic                                m_tuser,  // slice_valid
  output logic                                m_tlast,  // final_slice
  input  logic                                cfg_we,
  input  logic [cbs_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [cbs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import cbs_pkg::*;

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int CMP_W = (BURST_BITS > QUANT_BITS) ? BURST_BITS : QUANT_BITS;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_PROCS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_PROCS);

  state_t state, state_next;

  logic [POLICY_BITS-1:0] policy;
  logic [QUANT_BITS-1:0]  quantum;
  logic [CNT_W-1:0]       count;
  logic [TIME_BITS-1:0]   cur_time;
  logic [IDX_W-1:0]       turn_ptr;
  logic [IDX_W-1:0]       step;

  logic                   res_found;
  logic [IDX_W-1:0]       res_idx;
  logic [BURST_BITS-1:0]  res_run;
  logic                   res_final;

  logic                   in_xfer;
  logic                   load_out;
  logic                   rr;
  logic                   sjf;
  logic [BURST_BITS-1:0]  burst_in;
  cell_ctrl_t             ctrl;
  logic [IDX_W-1:0]       cell_addr;
  logic [BURST_BITS-1:0]  cell_data;
  logic [IDX_W-1:0]       thresh;

  logic                   pick_found;
  logic [IDX_W-1:0]       pick_idx;
  logic [BURST_BITS-1:0]  pick_rem;
  logic                   over_q;
  logic [TIME_BITS-1:0]   end_time;
  logic [IDX_W-1:0]       turn_next;

  wave_flags_t            wv_flags [MAX_PROCS+1];
  logic [IDX_W-1:0]       wv_idx   [MAX_PROCS+1];
  logic [BURST_BITS-1:0]  wv_rem   [MAX_PROCS+1];
  logic [BURST_BITS-1:0]  wv_key   [MAX_PROCS+1];
  logic [IDX_W-1:0]       wv_widx  [MAX_PROCS+1];
  logic [BURST_BITS-1:0]  wv_wrem  [MAX_PROCS+1];

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign rr       = (policy == POL_RR);
  assign sjf      = (policy == POL_SJF);
  assign burst_in = BURST_BITS'(s_tdata);
  assign thresh   = rr ? turn_ptr : '0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy  <= POL_FCFS;
      quantum <= QUANT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_POLICY:  policy  <= cfg_wdata[POLICY_BITS-1:0];
        REG_QUANTUM: quantum <= cfg_wdata[QUANT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and cell commands
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    ctrl.op    = CELL_NOP;
    ctrl.rr    = rr;
    ctrl.sjf   = sjf;
    cell_addr  = count[IDX_W-1:0];
    cell_data  = burst_in;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (s_tuser)
            ACT_CLEAR:  ctrl.op = CELL_CLEAR;
            ACT_APPEND: if (count < FULL_CNT) begin
              ctrl.op = CELL_APPEND;
            end
            ACT_REWIND: ctrl.op = CELL_REWIND;
            ACT_REQUEST: state_next = ST_SEARCH;
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (step == LAST_STEP) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
          if (res_found) begin
            ctrl.op   = CELL_RUN;
            cell_addr = res_idx;
            cell_data = res_run;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Row of process cells; the wave enters empty at cell 0
  assign wv_flags[0] = '0;
  assign wv_idx[0]   = '0;
  assign wv_rem[0]   = '0;
  assign wv_key[0]   = '0;
  assign wv_widx[0]  = '0;
  assign wv_wrem[0]  = '0;

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    cbs_cell #(
      .IDX_W      (IDX_W),
      .BURST_BITS (BURST_BITS),
      .CELL_INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .addr      (cell_addr),
      .data      (cell_data),
      .thresh    (thresh),
      .in_flags  (wv_flags[i]),
      .in_idx    (wv_idx[i]),
      .in_rem    (wv_rem[i]),
      .in_key    (wv_key[i]),
      .in_widx   (wv_widx[i]),
      .in_wrem   (wv_wrem[i]),
      .out_flags (wv_flags[i+1]),
      .out_idx   (wv_idx[i+1]),
      .out_rem   (wv_rem[i+1]),
      .out_key   (wv_key[i+1]),
      .out_widx  (wv_widx[i+1]),
      .out_wrem  (wv_wrem[i+1])
    );
  end

  // Decision from the wave at the end of the row
  always_comb begin
    if (rr) begin
      pick_found = (quantum != '0) &&
                   (wv_flags[MAX_PROCS].found || wv_flags[MAX_PROCS].wrap_found);
    end else begin
      pick_found = wv_flags[MAX_PROCS].found;
    end
    if (rr && !wv_flags[MAX_PROCS].found) begin
      pick_idx = wv_widx[MAX_PROCS];
      pick_rem = wv_wrem[MAX_PROCS];
    end else begin
      pick_idx = wv_idx[MAX_PROCS];
      pick_rem = wv_rem[MAX_PROCS];
    end
    over_q = rr && (CMP_W'(pick_rem) > CMP_W'(quantum));
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEARCH && step == LAST_STEP) begin
      res_found <= pick_found;
      res_idx   <= pick_idx;
      res_run   <= over_q ? BURST_BITS'(quantum) : pick_rem;
      res_final <= !wv_flags[MAX_PROCS].elig_cnt[1] && !over_q;
    end
  end

  // Search step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (in_xfer) begin
      step <= '0;
    end else if (state == ST_SEARCH) begin
      step <= step + 1'b1;
    end
  end

  assign end_time  = TIME_BITS'(cur_time + TIME_BITS'(res_run));
  assign turn_next = ((CNT_W'(res_idx) + 1'b1) == count) ? '0 : res_idx + 1'b1;

  // Table size, time and round-robin pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      cur_time <= '0;
      turn_ptr <= '0;
    end else begin
      if (in_xfer) begin
        case (s_tuser)
          ACT_CLEAR: begin
            count    <= '0;
            cur_time <= '0;
            turn_ptr <= '0;
          end
          ACT_APPEND: if (count < FULL_CNT) begin
            count <= count + 1'b1;
          end
          ACT_REWIND: begin
            cur_time <= '0;
            turn_ptr <= '0;
          end
          default: ;
        endcase
      end
      if (load_out && res_found) begin
        cur_time <= end_time;
        if (rr) begin
          turn_ptr <= turn_next;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= res_found;
      m_tlast <= res_found && res_final;
      if (res_found) begin
        m_tdata <= {7'd0, end_time, cur_time, PROC_BITS'(res_idx)};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

// File: hdl/cbs_checker.sv
module cbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [cbs_pkg::ACT_BITS-1:0]  s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [31:0]                   m_tdata,
  input logic                          m_tuser,
  input logic                          m_tlast
);
  import cbs_pkg::*;

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // An exhausted schedule reports all fields zero
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast)
    else $error("exhausted result carries data");

  // A request keeps the input side busy at the start of the search
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ACT_REQUEST) |=> !s_tready ##1 !s_tready)
    else $error("input taken during search");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

endmodule

bind cpu_burst_scheduler cbs_checker u_cbs_checker (.*);
